FILE: design/ber_pkg.sv
// Shared types, widths and the popcount function of the bit error rate counter.
package ber_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NBITS_W     = 6;
    localparam int unsigned LEN_W       = 13;
    localparam int unsigned FRAME_W     = 13;
    localparam int unsigned BIT_W       = 18;
    localparam int unsigned BYTE_W      = 15;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_RECV   = 2'd2,
        KIND_STATS  = 2'd3
    } kind_t;

    // What the front stage knows about an accepted item before the store read returns.
    typedef struct packed {
        logic              clr_stats;
        logic              cmp;
        logic              dropped;
        logic [LEN_W-1:0]  ref_len;
        logic [WORD_W-1:0] word;
    } meta_t;

    // One queued transaction for the statistics side.
    typedef struct packed {
        logic               clr_stats;
        logic               cmp;
        logic               err;
        logic [NBITS_W-1:0] nbits;
        logic               dropped;
        logic [LEN_W-1:0]   ref_len;
    } entry_t;

    function automatic logic [NBITS_W-1:0] popcount(input logic [WORD_W-1:0] v);
        logic [3:0]         lane_cnt [4];
        logic [NBITS_W-1:0] total;
        total = '0;
        for (int b = 0; b < 4; b++) begin
            lane_cnt[b] = '0;
            for (int i = 0; i < 8; i++) begin
                lane_cnt[b] = lane_cnt[b] + 4'(v[8*b+i]);
            end
            total = total + NBITS_W'(lane_cnt[b]);
        end
        return total;
    endfunction

endpackage

FILE: design/ber_if.sv
// Valid/ready channel interfaces for input items and result items.
interface ber_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] data_word;

    modport source (output valid, output kind, output data_word, input ready);
    modport sink   (input valid, input kind, input data_word, output ready);
endinterface

interface ber_out_if;
    logic        valid;
    logic        ready;
    logic        compared;
    logic        word_in_error;
    logic [5:0]  bit_errors_in_word;
    logic [17:0] total_bit_errors;
    logic [17:0] total_bits;
    logic [14:0] total_byte_errors;
    logic [14:0] total_bytes;
    logic [12:0] total_frame_errors;
    logic [12:0] total_frames;
    logic [12:0] reference_length;
    logic        load_dropped;

    modport source (
        output valid, output compared, output word_in_error, output bit_errors_in_word,
        output total_bit_errors, output total_bits, output total_byte_errors,
        output total_bytes, output total_frame_errors, output total_frames,
        output reference_length, output load_dropped, input ready
    );
    modport sink (
        input valid, input compared, input word_in_error, input bit_errors_in_word,
        input total_bit_errors, input total_bits, input total_byte_errors,
        input total_bytes, input total_frame_errors, input total_frames,
        input reference_length, input load_dropped, output ready
    );
endinterface

FILE: design/ber_front.sv
// Front stage: classifies items, owns the reference store and the compare position.
module ber_front #(
    parameter int unsigned REF_DEPTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    ber_in_if.sink           item,
    output logic             push_valid,
    output ber_pkg::entry_t  push_entry,
    input  logic             push_ready
);

    localparam int unsigned CW = $clog2(REF_DEPTH + 1);
    localparam int unsigned AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int unsigned LW = ber_pkg::LEN_W;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic                    s1_valid_reg, s1_valid_next;
    ber_pkg::meta_t          s1_meta_reg, meta_next;
    logic [31:0]             store [REF_DEPTH];
    logic [31:0]             rd_data_reg;
    logic [31:0]             diff;
    ber_pkg::kind_t          kind;
    logic                    accept;
    logic                    can_cmp;
    logic                    can_app;
    logic                    do_write;
    logic                    do_read;

    assign item.ready = !s1_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign kind       = ber_pkg::kind_t'(item.kind);
    assign can_cmp    = (count_reg != '0) && (pos_reg < count_reg);
    assign can_app    = count_reg < CW'(REF_DEPTH);
    assign do_write   = accept && (kind == ber_pkg::KIND_APPEND) && can_app;
    assign do_read    = accept && (kind == ber_pkg::KIND_RECV) && can_cmp;

    always_comb
    begin
        count_next          = count_reg;
        pos_next            = pos_reg;
        meta_next.clr_stats = 1'b0;
        meta_next.cmp       = 1'b0;
        meta_next.dropped   = 1'b0;
        meta_next.word      = item.data_word;
        if (accept)
        begin
            case (kind)
                ber_pkg::KIND_CLEAR:
                begin
                    count_next          = '0;
                    pos_next            = '0;
                    meta_next.clr_stats = 1'b1;
                end
                ber_pkg::KIND_APPEND:
                begin
                    if (can_app)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        meta_next.dropped = 1'b1;
                    end
                end
                ber_pkg::KIND_RECV:
                begin
                    if (can_cmp)
                    begin
                        pos_next      = pos_reg + 1'b1;
                        meta_next.cmp = 1'b1;
                    end
                end
                ber_pkg::KIND_STATS:
                begin
                    pos_next            = '0;
                    meta_next.clr_stats = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        meta_next.ref_len = LW'(count_next);
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
        end
    end

    // The read is issued at acceptance, so the word is ready when the item leaves this stage.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store[count_reg[AW-1:0]] <= item.data_word;
        end
        if (do_read)
        begin
            rd_data_reg <= store[pos_reg[AW-1:0]];
        end
    end

    assign diff       = s1_meta_reg.word ^ rd_data_reg;
    assign push_valid = s1_valid_reg;

    always_comb
    begin
        push_entry.clr_stats = s1_meta_reg.clr_stats;
        push_entry.cmp       = s1_meta_reg.cmp;
        push_entry.err       = s1_meta_reg.cmp && (diff != '0);
        push_entry.nbits     = s1_meta_reg.cmp ? ber_pkg::popcount(diff) : '0;
        push_entry.dropped   = s1_meta_reg.dropped;
        push_entry.ref_len   = s1_meta_reg.ref_len;
    end

endmodule

FILE: design/ber_fifo.sv
// Short queue that decouples the front stage from the statistics stage.
module ber_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  ber_pkg::entry_t  push_entry,
    output logic             push_ready,
    output logic             pop_valid,
    output ber_pkg::entry_t  pop_entry,
    input  logic             pop_ready
);

    localparam int unsigned DEPTH = ber_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned NW    = $clog2(DEPTH + 1);

    ber_pkg::entry_t  slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != NW'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/ber_back.sv
// Back stage: accumulates the error statistics and holds the result register.
module ber_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  ber_pkg::entry_t  pop_entry,
    output logic             pop_ready,
    ber_out_if.source        result
);

    localparam int unsigned FW = ber_pkg::FRAME_W;
    localparam int unsigned BW = ber_pkg::BIT_W;

    logic                        out_valid_reg;
    logic [FW-1:0]               frames_reg, frames_next;
    logic [FW-1:0]               ferr_reg, ferr_next;
    logic [BW-1:0]               bits_reg, bits_next;
    logic                        cmp_reg;
    logic                        err_reg;
    logic [ber_pkg::NBITS_W-1:0] nbits_reg;
    logic [ber_pkg::LEN_W-1:0]   len_reg;
    logic                        dropped_reg;
    logic                        load;

    assign pop_ready = !out_valid_reg || result.ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        frames_next = frames_reg;
        ferr_next   = ferr_reg;
        bits_next   = bits_reg;
        if (load)
        begin
            if (pop_entry.clr_stats)
            begin
                frames_next = '0;
                ferr_next   = '0;
                bits_next   = '0;
            end
            else if (pop_entry.cmp)
            begin
                frames_next = frames_reg + 1'b1;
                ferr_next   = ferr_reg + FW'(pop_entry.err);
                bits_next   = bits_reg + BW'(pop_entry.nbits);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            frames_reg    <= '0;
            ferr_reg      <= '0;
            bits_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            frames_reg <= frames_next;
            ferr_reg   <= ferr_next;
            bits_reg   <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmp_reg     <= pop_entry.cmp;
            err_reg     <= pop_entry.err;
            nbits_reg   <= pop_entry.nbits;
            len_reg     <= pop_entry.ref_len;
            dropped_reg <= pop_entry.dropped;
        end
    end

    // The counters change only when a new transaction enters the result register,
    // so they can drive the totals directly.
    assign result.valid              = out_valid_reg;
    assign result.compared           = cmp_reg;
    assign result.word_in_error      = err_reg;
    assign result.bit_errors_in_word = nbits_reg;
    assign result.total_bit_errors   = bits_reg;
    assign result.total_bits         = {frames_reg, 5'b0};
    assign result.total_byte_errors  = {ferr_reg, 2'b0};
    assign result.total_bytes        = {frames_reg, 2'b0};
    assign result.total_frame_errors = ferr_reg;
    assign result.total_frames       = frames_reg;
    assign result.reference_length   = len_reg;
    assign result.load_dropped       = dropped_reg;

endmodule

FILE: design/bit_error_rate_counter_core.sv
// Top level of the bit error rate counter.
// The block takes one transaction per cycle on the item channel while the output is not
// stalled and returns exactly one result transaction for each, in order; a result passes
// through the front stage with the registered read of the reference store, a two-entry
// queue and the result register. The single read port of the reference store is read
// when a received word is accepted, so the compare position advances once per cycle and
// back-to-back received words run at full rate while the output keeps up. The store is
// not cleared after reset; only entries below the reference length are ever read, so the
// block is ready as soon as reset is released. Totals wrap at their field widths.
module bit_error_rate_counter_core #(
    parameter int unsigned REF_DEPTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    ber_in_if.sink     item,
    ber_out_if.source  result
);

    logic             push_valid;
    logic             push_ready;
    ber_pkg::entry_t  push_entry;
    logic             pop_valid;
    logic             pop_ready;
    ber_pkg::entry_t  pop_entry;

    ber_front #(
        .REF_DEPTH (REF_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    ber_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    ber_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

FILE: design/ber_checker.sv
// Port-level assertions for the bit error rate counter and their bind to the top level.
module ber_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        compared,
    input logic        word_in_error,
    input logic [5:0]  bit_errors_in_word,
    input logic [17:0] total_bits,
    input logic [12:0] total_frames,
    input logic        load_dropped
);

    // A transaction that did not compare carries no per-word error information.
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !compared |-> !word_in_error && (bit_errors_in_word == 6'd0))
        else $error("per-word error fields set on a transaction that did not compare");

    a_err_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && compared |-> word_in_error == (bit_errors_in_word != 6'd0))
        else $error("word error flag disagrees with the bit error count");

    a_bits_track_frames: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (total_bits[17:5] == total_frames) && (total_bits[4:0] == 5'd0))
        else $error("bit total is not 32 times the frame total");

    a_drop_not_compare: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && load_dropped |-> !compared)
        else $error("a dropped append also reports a compare");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(total_frames))
        else $error("result changed while stalled");

endmodule

bind bit_error_rate_counter_core ber_checker u_ber_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .compared           (result.compared),
    .word_in_error      (result.word_in_error),
    .bit_errors_in_word (result.bit_errors_in_word),
    .total_bits         (result.total_bits),
    .total_frames       (result.total_frames),
    .load_dropped       (result.load_dropped)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the bit error rate counter core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH        = 4096;
    localparam int unsigned RANDOM_ITEMS = 1330;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned LIMIT_CYCLES = 500000;

    // Traffic phases: which side of the link idles.
    localparam int unsigned PHASE_RX_SLOW   = 0;
    localparam int unsigned PHASE_TX_SLOW   = 1;
    localparam int unsigned PHASE_FULL_RATE = 2;

    typedef struct {
        ber_pkg::kind_t kind;
        logic [31:0]    word;
        int unsigned    phase;
        bit             drain;
        bit             hold_rx;
    } stim_t;

    typedef struct packed {
        logic        compared;
        logic        word_in_error;
        logic [5:0]  bit_errors_in_word;
        logic [17:0] total_bit_errors;
        logic [17:0] total_bits;
        logic [14:0] total_byte_errors;
        logic [14:0] total_bytes;
        logic [12:0] total_frame_errors;
        logic [12:0] total_frames;
        logic [12:0] reference_length;
        logic        load_dropped;
    } ber_result_t;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           drv_valid = 1'b0;
    ber_pkg::kind_t drv_kind  = ber_pkg::KIND_CLEAR;
    logic [31:0]    drv_word  = '0;
    logic           drv_rdy   = 1'b0;

    ber_in_if  item_if ();
    ber_out_if result_if ();

    assign item_if.valid     = drv_valid;
    assign item_if.kind      = drv_kind;
    assign item_if.data_word = drv_word;
    assign result_if.ready   = drv_rdy;

    bit_error_rate_counter_core #(
        .REF_DEPTH(DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .result(result_if)
    );

    // Stimulus side
    stim_t       stim_q[$];
    int unsigned items_queued = 0;
    int unsigned gen_phase = PHASE_RX_SLOW;
    bit          gen_drain = 1'b0;
    bit          gen_hold  = 1'b0;
    logic [31:0] gen_ref[$];
    int unsigned gen_pos = 0;

    // Expected behavior of the counter
    logic [31:0] golden_ref [DEPTH];
    int unsigned golden_len        = 0;
    int unsigned golden_frames     = 0;
    int unsigned golden_frame_errs = 0;
    int unsigned golden_bit_errs   = 0;
    ber_result_t expected_q[$];
    int unsigned pending_results = 0;

    // Handshake control between driver and sink
    int unsigned tx_phase    = PHASE_RX_SLOW;
    bit          rx_hold_req = 1'b0;
    bit          hold_done   = 1'b0;
    int unsigned hold_left   = 0;

    // Run bookkeeping
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned n_compared   = 0;
    int unsigned n_word_errs  = 0;
    int unsigned n_dropped    = 0;
    int unsigned n_ignored    = 0;
    int unsigned n_clears     = 0;
    int unsigned n_stat_resets = 0;
    int unsigned max_len      = 0;
    int unsigned cycle_count  = 0;

    function automatic int unsigned idle_pct(input bit receiver, input int unsigned phase);
        case (phase)
            PHASE_RX_SLOW: return receiver ? 85 : 26;
            PHASE_TX_SLOW: return receiver ? 26 : 85;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 10)
            return 32'h0000_0000;
        if (pick < 20)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // A received word built around the reference word that the block will compare next.
    function automatic logic [31:0] received_word();
        logic [31:0] base;
        int unsigned pick;
        base = (gen_pos < gen_ref.size()) ? gen_ref[gen_pos] : $urandom;
        pick = $urandom_range(99, 0);
        if (pick < 45)
            return base;
        if (pick < 65)
            return base ^ (32'd1 << $urandom_range(31, 0));
        if (pick < 80)
            return base ^ ($urandom & $urandom & $urandom);
        if (pick < 90)
            return ~base;
        return $urandom;
    endfunction

    function automatic void queue_item(input ber_pkg::kind_t k, input logic [31:0] w);
        stim_t s;
        s.kind    = k;
        s.word    = w;
        s.phase   = gen_phase;
        s.drain   = gen_drain;
        s.hold_rx = gen_hold;
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
        stim_q.push_back(s);
        items_queued++;
        case (k)
            ber_pkg::KIND_CLEAR:
            begin
                gen_ref.delete();
                gen_pos = 0;
            end
            ber_pkg::KIND_APPEND:
            begin
                if (gen_ref.size() < DEPTH)
                    gen_ref.push_back(w);
            end
            ber_pkg::KIND_RECV:
            begin
                if (gen_pos < gen_ref.size())
                    gen_pos++;
            end
            default:
                gen_pos = 0;
        endcase
    endfunction

    function automatic ber_result_t ber_predict(input ber_pkg::kind_t k, input logic [31:0] w);
        ber_result_t r;
        logic [31:0] diff;
        r = '0;
        case (k)
            ber_pkg::KIND_CLEAR:
            begin
                golden_len        = 0;
                golden_frames     = 0;
                golden_frame_errs = 0;
                golden_bit_errs   = 0;
            end
            ber_pkg::KIND_APPEND:
            begin
                if (golden_len < DEPTH) begin
                    golden_ref[golden_len] = w;
                    golden_len++;
                end else begin
                    r.load_dropped = 1'b1;
                end
            end
            ber_pkg::KIND_RECV:
            begin
                // Position is the number of frames compared since the last reset.
                if (golden_frames < golden_len) begin
                    diff = w ^ golden_ref[golden_frames];
                    r.compared           = 1'b1;
                    r.word_in_error      = (diff != '0);
                    r.bit_errors_in_word = 6'($countones(diff));
                    golden_frames++;
                    golden_frame_errs += r.word_in_error;
                    golden_bit_errs   += r.bit_errors_in_word;
                end
            end
            default:
            begin
                golden_frames     = 0;
                golden_frame_errs = 0;
                golden_bit_errs   = 0;
            end
        endcase
        r.total_bit_errors   = 18'(golden_bit_errs);
        r.total_bits         = 18'(golden_frames * 32);
        r.total_byte_errors  = 15'(golden_frame_errs * 4);
        r.total_bytes        = 15'(golden_frames * 4);
        r.total_frame_errors = 13'(golden_frame_errs);
        r.total_frames       = 13'(golden_frames);
        r.reference_length   = 13'(golden_len);
        return r;
    endfunction

    function automatic string fmt_result(input ber_result_t r);
        return $sformatf({"cmp=%0d err=%0d nbits=%0d biterr=%0d bits=%0d byteerr=%0d ",
                          "bytes=%0d frmerr=%0d frames=%0d len=%0d drop=%0d"},
                         r.compared, r.word_in_error, r.bit_errors_in_word,
                         r.total_bit_errors, r.total_bits, r.total_byte_errors,
                         r.total_bytes, r.total_frame_errors, r.total_frames,
                         r.reference_length, r.load_dropped);
    endfunction

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        stim_t nxt;
        if (!rst_n) begin
            drv_valid   <= 1'b0;
            drv_kind    <= ber_pkg::KIND_CLEAR;
            drv_word    <= '0;
            rx_hold_req <= 1'b0;
            tx_phase    <= PHASE_RX_SLOW;
        end else if (!drv_valid || item_if.ready) begin
            if (stim_q.size() == 0) begin
                drv_valid <= 1'b0;
            end else begin
                nxt = stim_q[0];
                // A draining transaction waits until the block has returned every result.
                if ((nxt.drain && (drv_valid || pending_results != 0))
                    || $urandom_range(99, 0) < idle_pct(1'b0, nxt.phase)) begin
                    drv_valid <= 1'b0;
                end else begin
                    void'(stim_q.pop_front());
                    drv_valid <= 1'b1;
                    drv_kind  <= nxt.kind;
                    drv_word  <= nxt.word;
                    tx_phase  <= nxt.phase;
                    if (nxt.hold_rx)
                        rx_hold_req <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_sink
        if (!rst_n) begin
            drv_rdy   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            drv_rdy   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            drv_rdy   <= 1'b0;
        end else begin
            drv_rdy <= ($urandom_range(99, 0) >= idle_pct(1'b1, tx_phase));
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        ber_result_t want;
        ber_result_t seen;
        if (!rst_n) begin
            pending_results <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                want = ber_predict(ber_pkg::kind_t'(item_if.kind), item_if.data_word);
                expected_q.push_back(want);
                n_compared  += want.compared;
                n_word_errs += want.word_in_error;
                n_dropped   += want.load_dropped;
                if (ber_pkg::kind_t'(item_if.kind) == ber_pkg::KIND_RECV && !want.compared)
                    n_ignored++;
                if (ber_pkg::kind_t'(item_if.kind) == ber_pkg::KIND_CLEAR)
                    n_clears++;
                if (ber_pkg::kind_t'(item_if.kind) == ber_pkg::KIND_STATS)
                    n_stat_resets++;
                if (golden_len > max_len)
                    max_len = golden_len;
            end
            if (result_if.valid && result_if.ready) begin
                seen.compared           = result_if.compared;
                seen.word_in_error      = result_if.word_in_error;
                seen.bit_errors_in_word = result_if.bit_errors_in_word;
                seen.total_bit_errors   = result_if.total_bit_errors;
                seen.total_bits         = result_if.total_bits;
                seen.total_byte_errors  = result_if.total_byte_errors;
                seen.total_bytes        = result_if.total_bytes;
                seen.total_frame_errors = result_if.total_frame_errors;
                seen.total_frames       = result_if.total_frames;
                seen.reference_length   = result_if.reference_length;
                seen.load_dropped       = result_if.load_dropped;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result transaction: %s", fmt_result(seen));
                end else begin
                    want = expected_q.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(seen));
                        end
                    end
                end
                results_seen++;
            end
            pending_results <= expected_q.size();
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned directed_items;
        int unsigned rnd_count;
        int unsigned new_phase;
        int unsigned len;
        int unsigned n_recv;
        int unsigned remaining;
        int unsigned pick;

        // Empty store, exact and fully inverted words, used-up reference,
        // append after compares, statistics reset, clear with data present.
        queue_item(ber_pkg::KIND_RECV,   32'h0000_0000);
        queue_item(ber_pkg::KIND_STATS,  32'hFFFF_FFFF);
        queue_item(ber_pkg::KIND_APPEND, 32'h0000_0000);
        queue_item(ber_pkg::KIND_APPEND, 32'hFFFF_FFFF);
        queue_item(ber_pkg::KIND_APPEND, 32'hA5A5_A5A5);
        queue_item(ber_pkg::KIND_RECV,   32'h0000_0000);
        queue_item(ber_pkg::KIND_RECV,   32'h0000_0000);
        queue_item(ber_pkg::KIND_RECV,   32'h5A5A_5A5A);
        queue_item(ber_pkg::KIND_RECV,   32'h1234_5678);
        queue_item(ber_pkg::KIND_STATS,  32'h0000_0000);
        queue_item(ber_pkg::KIND_RECV,   32'h0000_0001);
        queue_item(ber_pkg::KIND_APPEND, 32'h0F0F_0F0F);
        queue_item(ber_pkg::KIND_RECV,   32'hFFFF_FFFF);
        queue_item(ber_pkg::KIND_RECV,   32'hA5A5_A5A4);
        queue_item(ber_pkg::KIND_RECV,   32'h0F0F_0F0F);
        queue_item(ber_pkg::KIND_RECV,   32'hFFFF_FFFF);
        queue_item(ber_pkg::KIND_CLEAR,  32'hFFFF_FFFF);
        queue_item(ber_pkg::KIND_RECV,   32'hFFFF_FFFF);
        queue_item(ber_pkg::KIND_APPEND, 32'h8000_0000);
        queue_item(ber_pkg::KIND_RECV,   32'h7FFF_FFFF);
        queue_item(ber_pkg::KIND_CLEAR,  32'h0000_0000);

        directed_items = items_queued;
        rnd_count  = 0;
        while (rnd_count < RANDOM_ITEMS) begin
            new_phase = rnd_count * 3 / RANDOM_ITEMS;
            if (new_phase != gen_phase) begin
                gen_phase = new_phase;
                gen_drain = 1'b1;
                // The sink holds off at the start of the full-rate phase so the block
                // backs up and stalls its input.
                if (gen_phase == PHASE_FULL_RATE)
                    gen_hold = 1'b1;
            end
            if ($urandom_range(99, 0) < 75) begin
                // Well-formed burst: optional restart, reference load, then received words.
                pick = $urandom_range(99, 0);
                if (pick < 55)
                    queue_item(ber_pkg::KIND_CLEAR, rand_word());
                else if (pick < 75)
                    queue_item(ber_pkg::KIND_STATS, rand_word());
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 25)
                                                  : $urandom_range(24, 1);
                for (int i = 0; i < len; i++)
                    queue_item(ber_pkg::KIND_APPEND, rand_word());
                remaining = gen_ref.size() - gen_pos;
                if (remaining > 150)
                    remaining = 150;
                n_recv = remaining + $urandom_range(2, 0);
                if ($urandom_range(3, 0) == 0)
                    n_recv = $urandom_range(remaining, 0);
                for (int i = 0; i < n_recv; i++) begin
                    if ($urandom_range(11, 0) == 0)
                        queue_item(ber_pkg::KIND_APPEND, rand_word());
                    queue_item(ber_pkg::KIND_RECV, received_word());
                end
            end else begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(3, 0);
                    queue_item(ber_pkg::kind_t'(pick),
                               (ber_pkg::kind_t'(pick) == ber_pkg::KIND_RECV)
                                   ? received_word() : rand_word());
                end
            end
            rnd_count = items_queued - directed_items;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || drv_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d transactions in %0d cycles: %0d words compared, %0d in error",
                 results_seen, cycle_count, n_compared, n_word_errs);
        $display("  %0d appends dropped, %0d words ignored, %0d clears, %0d stat resets",
                 n_dropped, n_ignored, n_clears, n_stat_resets);
        $display("  longest reference held: %0d words", max_len);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
design/ber_pkg.sv
design/ber_if.sv
design/ber_front.sv
design/ber_fifo.sv
design/ber_back.sv
design/bit_error_rate_counter_core.sv
design/ber_checker.sv
tb/tb_top.sv
